// ===== hdl/wbps_pkg.sv =====
// Shared types and constants of the wildcard byte pattern search block.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none
package wbps_pkg;

   localparam int PATTERN_SLOTS  = 32;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_3 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WILDCARD  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LENGTH    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMIT     = 3'd6;

   localparam logic KIND_MATCH = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   localparam logic [31:0] POS_MAX     = 32'hFFFF_FFFF;
   localparam logic [7:0]  LIMIT_RESET = 8'd255;

   typedef struct packed {
      logic [PATTERN_SLOTS*8-1:0] pattern_bytes;
      logic [PATTERN_SLOTS-1:0]   wildcard_mask;
      logic [5:0]                 pattern_length;
      logic [7:0]                 match_limit;
   } cfg_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] match_offset;
      logic [7:0]  match_total;
      logic        final_result;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage
`default_nettype wire

// ===== hdl/wbps_ifs.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on nothing.
`default_nettype none
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       region_end;

   modport source (output valid, output data_byte, output region_end, input ready);
   modport sink (input valid, input data_byte, input region_end, output ready);
endinterface

interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [31:0] match_offset;
   logic [7:0]  match_total;
   logic        final_result;

   modport source (output valid, output result_kind, output match_offset,
                   output match_total, output final_result, input ready);
   modport sink (input valid, input result_kind, input match_offset,
                 input match_total, input final_result, output ready);
endinterface
`default_nettype wire

// ===== hdl/wbps_csr.sv =====
// Configuration registers: pattern bytes, wildcard mask, length and match limit.
// Depends on wbps_pkg.
`default_nettype none
module wbps_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [wbps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [wbps_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   output wbps_pkg::cfg_type                          cfg
);

   logic [3:0][63:0] pattern_ff, pattern_in;
   logic [31:0]      wildcard_ff, wildcard_in;
   logic [5:0]       length_ff, length_in;
   logic [7:0]       limit_ff, limit_in;

   always_comb begin
      pattern_in  = pattern_ff;
      wildcard_in = wildcard_ff;
      length_in   = length_ff;
      limit_in    = limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            wbps_pkg::CSR_PATTERN_0: pattern_in[0] = csr_write_data;
            wbps_pkg::CSR_PATTERN_1: pattern_in[1] = csr_write_data;
            wbps_pkg::CSR_PATTERN_2: pattern_in[2] = csr_write_data;
            wbps_pkg::CSR_PATTERN_3: pattern_in[3] = csr_write_data;
            wbps_pkg::CSR_WILDCARD:  wildcard_in   = csr_write_data[31:0];
            wbps_pkg::CSR_LENGTH:    length_in     = csr_write_data[5:0];
            wbps_pkg::CSR_LIMIT:     limit_in      = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         wildcard_ff <= '0;
         length_ff   <= '0;
         limit_ff    <= wbps_pkg::LIMIT_RESET;
      end else begin
         pattern_ff  <= pattern_in;
         wildcard_ff <= wildcard_in;
         length_ff   <= length_in;
         limit_ff    <= limit_in;
      end
   end

   assign cfg.pattern_bytes  = pattern_ff;
   assign cfg.wildcard_mask  = wildcard_ff;
   assign cfg.pattern_length = length_ff;
   assign cfg.match_limit    = limit_ff;

endmodule
`default_nettype wire

// ===== hdl/wbps_scan.sv =====
// Input register, per-position compare cells and region state; emits up to
// two results per byte. Depends on wbps_pkg and wbps_ifs.
`default_nettype none
module wbps_scan #(
   parameter int PATTERN_MAX = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   wbps_req_if.sink          req_chan,
   input  wire wbps_pkg::cfg_type cfg,
   input  wire logic         queue_room,
   output wbps_pkg::push_type push
);

   localparam int CAP   = (PATTERN_MAX < wbps_pkg::PATTERN_SLOTS) ?
                          PATTERN_MAX : wbps_pkg::PATTERN_SLOTS;
   localparam int LEN_W = $clog2(CAP + 1);

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic [CAP-1:0]   partial_ff, partial_in;
   logic [31:0]      pos_ff, pos_in;
   logic [7:0]       found_ff, found_in;

   logic             fire;
   logic [LEN_W-1:0] len;
   logic [CAP-1:0]   len_mask, top_sel, match_vec, cand, now;
   logic             hit, hit_ok;
   logic [31:0]      offset;
   logic [7:0]       total;
   wbps_pkg::result_type match_res, done_res;

   assign fire          = in_valid_ff && queue_room;
   assign req_chan.ready = !in_valid_ff || fire;

   always_comb begin
      if (int'(cfg.pattern_length) > CAP) begin
         len = LEN_W'(CAP);
      end else begin
         len = cfg.pattern_length[LEN_W-1:0];
      end
      for (int j = 0; j < CAP; j++) begin
         len_mask[j]  = (j < int'(len));
         top_sel[j]   = (int'(len) == j + 1);
         match_vec[j] = cfg.wildcard_mask[j] || (cfg.pattern_bytes[8*j +: 8] == in_byte_ff);
      end
      cand   = CAP'({partial_ff, 1'b1}) & len_mask;
      now    = cand & match_vec;
      hit    = |(now & top_sel);
      hit_ok = hit && (found_ff < cfg.match_limit);
      offset = (pos_ff == wbps_pkg::POS_MAX) ? wbps_pkg::POS_MAX :
               pos_ff + 32'd1 - 32'(len);
      total  = found_ff + 8'(hit_ok);
   end

   always_comb begin
      match_res.result_kind  = wbps_pkg::KIND_MATCH;
      match_res.match_offset = offset;
      match_res.match_total  = total;
      match_res.final_result = !in_last_ff;
      done_res.result_kind   = wbps_pkg::KIND_DONE;
      done_res.match_offset  = '0;
      done_res.match_total   = total;
      done_res.final_result  = 1'b1;

      push.count  = '0;
      push.first  = match_res;
      push.second = done_res;
      if (fire) begin
         if (hit_ok) begin
            push.count = in_last_ff ? 2'd2 : 2'd1;
         end else if (in_last_ff) begin
            push.count = 2'd1;
            push.first = done_res;
         end
      end
   end

   always_comb begin
      partial_in = partial_ff;
      pos_in     = pos_ff;
      found_in   = found_ff;
      if (fire) begin
         if (in_last_ff) begin
            partial_in = '0;
            pos_in     = '0;
            found_in   = '0;
         end else begin
            partial_in = hit_ok ? '0 : now;
            pos_in     = (pos_ff == wbps_pkg::POS_MAX) ? pos_ff : pos_ff + 32'd1;
            found_in   = total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         partial_ff  <= '0;
         pos_ff      <= '0;
         found_ff    <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         partial_ff <= partial_in;
         pos_ff     <= pos_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.region_end;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/wbps_rsp_fifo.sv =====
// Small result queue taking up to two results per cycle and sending at most one.
// Depends on wbps_pkg and wbps_ifs.
`default_nettype none
module wbps_rsp_fifo (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire wbps_pkg::push_type push,
   output logic               queue_room,
   wbps_rsp_if.source         rsp_chan
);

   localparam int PTR_W = $clog2(wbps_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(wbps_pkg::QUEUE_DEPTH + 1);

   wbps_pkg::result_type entry_ff [wbps_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   wbps_pkg::result_type head;

   assign head       = entry_ff[rd_ptr_ff];
   assign pop        = rsp_chan.valid && rsp_chan.ready;
   assign queue_room = (count_ff <= CNT_W'(wbps_pkg::QUEUE_DEPTH - 2));

   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.result_kind  = head.result_kind;
   assign rsp_chan.match_offset = head.match_offset;
   assign rsp_chan.match_total  = head.match_total;
   assign rsp_chan.final_result = head.final_result;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.second;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/wildcard_byte_pattern_search.sv =====
// Wildcard byte pattern search: one byte per cycle against up to 32 pattern
// positions, each compared in parallel. A byte is registered on transfer; its
// compare, match update and results follow once the result queue has room, and
// its results are written into that queue, whose head drives the output. A byte
// that both completes a match and ends the region produces two results, which a
// four-entry result queue absorbs; the input stalls only while that queue holds
// more than two results, so with a ready consumer the sustained rate is one byte
// per cycle as long as bytes average no more than one result each. Matches do
// not overlap and stop at match_limit per region. Configuration is to be
// written only while the block is idle; the block itself does not enforce this.
// Depends on wbps_pkg, wbps_ifs, wbps_csr, wbps_scan and wbps_rsp_fifo.
`default_nettype none
module wildcard_byte_pattern_search #(
   parameter int PATTERN_MAX = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   wbps_req_if.sink                                  req_chan,
   wbps_rsp_if.source                                rsp_chan,
   input  wire logic                                 csr_write_enable,
   input  wire logic [wbps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [wbps_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   wbps_pkg::cfg_type  cfg;
   wbps_pkg::push_type push;
   logic               queue_room;

   wbps_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   wbps_scan #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg),
      .queue_room (queue_room),
      .push       (push)
   );

   wbps_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .queue_room (queue_room),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire

// ===== dv/wbps_match_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the wildcard byte pattern search: tracks register writes,
// predicts the results of every byte transfer and compares each result transfer.
// Depends on wbps_pkg and the channel interfaces in wbps_ifs.
module wbps_match_checker #(
   parameter int PATTERN_MAX = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   wbps_req_if                                       req_mon,
   wbps_rsp_if                                       rsp_mon,
   input  wire logic                                 csr_write_enable,
   input  wire logic [wbps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [wbps_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                                        failures,
   output int                                        pending
);

   logic [63:0] pattern_words [4];
   logic [31:0] wild_bits;
   logic [5:0]  length_cfg;
   logic [7:0]  limit_cfg;

   logic [31:0] partial_bits;
   logic [31:0] byte_count;
   logic [7:0]  found;

   wbps_pkg::result_type expected_results [$];

   initial failures = 0;

   task automatic scan_byte(input logic [7:0] data, input logic last);
      int unsigned len;
      int j;
      logic [31:0] len_mask;
      logic [31:0] accepted;
      logic [31:0] live;
      wbps_pkg::result_type hit;
      len = int'(length_cfg);
      if (len > PATTERN_MAX) len = PATTERN_MAX;
      if (len > 32) len = 32;
      if (len == 0) begin
         partial_bits = '0;
      end else begin
         len_mask = (len == 32) ? '1 : ((32'd1 << len) - 32'd1);
         accepted = '0;
         for (j = 0; j < len; j++) begin
            if (wild_bits[j] || pattern_words[j / 8][(j % 8) * 8 +: 8] == data)
               accepted[j] = 1'b1;
         end
         live = ((partial_bits << 1) | 32'd1) & len_mask & accepted;
         if (live[len - 1] && found < limit_cfg) begin
            found = found + 8'd1;
            hit.result_kind  = wbps_pkg::KIND_MATCH;
            hit.match_offset = (byte_count == wbps_pkg::POS_MAX) ? wbps_pkg::POS_MAX
                                                                 : byte_count + 32'd1 - 32'(len);
            hit.match_total  = found;
            hit.final_result = !last;
            expected_results.push_back(hit);
            live = '0;
         end
         partial_bits = live;
      end
      if (byte_count != wbps_pkg::POS_MAX) byte_count = byte_count + 32'd1;
      if (last) begin
         hit.result_kind  = wbps_pkg::KIND_DONE;
         hit.match_offset = '0;
         hit.match_total  = found;
         hit.final_result = 1'b1;
         expected_results.push_back(hit);
         partial_bits = '0;
         byte_count   = '0;
         found        = '0;
      end
   endtask

   task automatic check_result();
      wbps_pkg::result_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result: result_kind %0d match_offset %0d %s %0d %s %0d",
                rsp_mon.result_kind, rsp_mon.match_offset,
                "match_total", rsp_mon.match_total,
                "final_result", rsp_mon.final_result);
         failures++;
      end else begin
         want = expected_results.pop_front();
         if (rsp_mon.result_kind !== want.result_kind) begin
            $error("result_kind expected %0d actual %0d", want.result_kind,
                   rsp_mon.result_kind);
            failures++;
         end
         if (rsp_mon.match_offset !== want.match_offset) begin
            $error("match_offset expected %0d actual %0d", want.match_offset,
                   rsp_mon.match_offset);
            failures++;
         end
         if (rsp_mon.match_total !== want.match_total) begin
            $error("match_total expected %0d actual %0d", want.match_total,
                   rsp_mon.match_total);
            failures++;
         end
         if (rsp_mon.final_result !== want.final_result) begin
            $error("final_result expected %0d actual %0d", want.final_result,
                   rsp_mon.final_result);
            failures++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern_words[0] = '0;
         pattern_words[1] = '0;
         pattern_words[2] = '0;
         pattern_words[3] = '0;
         wild_bits    = '0;
         length_cfg   = '0;
         limit_cfg    = wbps_pkg::LIMIT_RESET;
         partial_bits = '0;
         byte_count   = '0;
         found        = '0;
         expected_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               wbps_pkg::CSR_PATTERN_0: pattern_words[0] = csr_write_data;
               wbps_pkg::CSR_PATTERN_1: pattern_words[1] = csr_write_data;
               wbps_pkg::CSR_PATTERN_2: pattern_words[2] = csr_write_data;
               wbps_pkg::CSR_PATTERN_3: pattern_words[3] = csr_write_data;
               wbps_pkg::CSR_WILDCARD:  wild_bits  = csr_write_data[31:0];
               wbps_pkg::CSR_LENGTH:    length_cfg = csr_write_data[5:0];
               wbps_pkg::CSR_LIMIT:     limit_cfg  = csr_write_data[7:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            scan_byte(req_mon.data_byte, req_mon.region_end);
         if (rsp_mon.valid && rsp_mon.ready)
            check_result();
      end
      pending <= expected_results.size();
   end

endmodule

// ===== dv/tb_wildcard_byte_pattern_search.sv =====
`timescale 1ns / 100ps
// Testbench top for the wildcard byte pattern search: drives bytes, register
// writes and result backpressure, and reports the verdict of wbps_match_checker.
// Depends on wbps_pkg, wbps_ifs, wbps_match_checker and the block itself.
module tb_wildcard_byte_pattern_search;

   localparam int PATTERN_MAX = 32;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEM_TARGET = 1050;
   localparam int QUIET_TAIL  = 150;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 csr_write_enable = 1'b0;
   logic [wbps_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [wbps_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   int failures;
   int pending;
   int sent = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit long_hold = 1'b0;

   wbps_req_if req_chan ();
   wbps_rsp_if rsp_chan ();

   wildcard_byte_pattern_search #(
      .PATTERN_MAX (PATTERN_MAX)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   wbps_match_checker #(
      .PATTERN_MAX (PATTERN_MAX)
   ) scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .pending          (pending)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("wildcard_byte_pattern_search verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [7:0] pick_symbol(input bit narrow, input logic [7:0] base);
      return narrow ? base + 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
   endfunction

   task automatic offer(input logic [7:0] data, input logic last);
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= data;
      req_chan.region_end <= last;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [wbps_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [wbps_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic load_config(input logic [255:0] bytes, input logic [31:0] mask,
                              input logic [5:0] length, input logic [7:0] limit);
      write_reg(wbps_pkg::CSR_PATTERN_0, bytes[63:0]);
      write_reg(wbps_pkg::CSR_PATTERN_1, bytes[127:64]);
      write_reg(wbps_pkg::CSR_PATTERN_2, bytes[191:128]);
      write_reg(wbps_pkg::CSR_PATTERN_3, bytes[255:192]);
      write_reg(wbps_pkg::CSR_WILDCARD, {32'd0, mask});
      write_reg(wbps_pkg::CSR_LENGTH, {58'd0, length});
      write_reg(wbps_pkg::CSR_LIMIT, {56'd0, limit});
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_phase(input int phase_no, input int budget);
      logic [255:0] bytes;
      logic [31:0]  mask;
      logic [5:0]   length;
      logic [7:0]   limit;
      logic [7:0]   base;
      bit           narrow;
      int           eff;
      int           cut;
      int           start;
      int           i;
      int           k;
      logic [7:0]   region [$];
      narrow = 1'($urandom_range(0, 1));
      base   = 8'($urandom_range(0, 255));
      for (i = 0; i < 32; i++) bytes[i * 8 +: 8] = pick_symbol(narrow, base);
      case ($urandom_range(0, 9))
         0:       length = 6'd0;
         1:       length = 6'd32;
         2:       length = 6'($urandom_range(33, 63));
         default: length = 6'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 5))
         0:       mask = '0;
         1:       mask = '1;
         2:       mask = $urandom;
         default: mask = $urandom & $urandom & $urandom;
      endcase
      case ($urandom_range(0, 9))
         0:       limit = 8'd0;
         1:       limit = 8'd1;
         2:       limit = 8'($urandom_range(2, 5));
         3:       limit = 8'($urandom_range(0, 255));
         default: limit = wbps_pkg::LIMIT_RESET;
      endcase
      if (phase_no == 0) begin
         length = 6'd63;
         limit  = wbps_pkg::LIMIT_RESET;
      end else if (phase_no == 1) begin
         bytes  = '1;
         mask   = '0;
         length = 6'd32;
         limit  = wbps_pkg::LIMIT_RESET;
         narrow = 1'b1;
         base   = 8'hFE;
      end
      load_config(bytes, mask, length, limit);
      eff = (length > 6'd32) ? 32 : int'(length);
      start = sent;
      while (sent - start < budget) begin
         region.delete();
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  for (i = 0; i < eff; i++)
                     region.push_back(mask[i] ? pick_symbol(narrow, base) : bytes[i * 8 +: 8]);
                  if (eff == 0) region.push_back(pick_symbol(narrow, base));
               end
               5, 6: begin
                  cut = (eff > 1) ? int'($urandom_range(1, eff - 1)) : 0;
                  for (i = 0; i < cut; i++)
                     region.push_back(mask[i] ? pick_symbol(narrow, base) : bytes[i * 8 +: 8]);
                  region.push_back(pick_symbol(narrow, base));
               end
               default: begin
                  repeat ($urandom_range(1, 4)) region.push_back(pick_symbol(narrow, base));
               end
            endcase
         end
         for (k = 0; k < region.size(); k++) offer(region[k], k == region.size() - 1);
      end
      settle();
   endtask

   initial begin
      int phase_no;
      int i;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= '0;
      req_chan.region_end <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero pattern length straight out of reset
      offer(8'h00, 1'b0);
      offer(8'hFF, 1'b1);
      settle();

      // pattern 41 42 ?? 44, then a hit on the region's last byte
      load_config(256'h44_00_42_41, 32'h0000_0004, 6'd4, wbps_pkg::LIMIT_RESET);
      offer(8'h41, 1'b0);
      offer(8'h42, 1'b0);
      offer(8'h7E, 1'b0);
      offer(8'h44, 1'b0);
      offer(8'h41, 1'b0);
      offer(8'h42, 1'b0);
      offer(8'hFF, 1'b0);
      offer(8'h44, 1'b1);
      settle();

      // change the length in the middle of a region
      offer(8'h41, 1'b0);
      offer(8'h42, 1'b0);
      settle();
      load_config(256'h44_00_42_41, 32'h0000_0004, 6'd2, wbps_pkg::LIMIT_RESET);
      offer(8'h41, 1'b0);
      offer(8'h42, 1'b1);
      settle();

      // zero match limit
      load_config(256'h0, 32'h0, 6'd1, 8'd0);
      offer(8'h00, 1'b0);
      offer(8'h00, 1'b1);
      settle();

      // limit reached: third completion goes unreported
      load_config({256{1'b1}}, 32'h0000_0001, 6'd1, 8'd2);
      offer(8'h01, 1'b0);
      offer(8'h02, 1'b0);
      offer(8'h03, 1'b1);
      settle();

      // hold off results until the input stalls
      load_config({8{$urandom}}, 32'h0000_0001, 6'd1, wbps_pkg::LIMIT_RESET);
      long_hold = 1'b1;
      for (i = 0; i < 60; i++) offer(8'($urandom_range(0, 255)), i == 59);
      settle();

      phase_no = 0;
      while (sent < ITEM_TARGET - QUIET_TAIL) begin
         random_phase(phase_no, $urandom_range(40, 120));
         phase_no++;
      end
      quiet = 1'b1;
      while (sent < ITEM_TARGET) begin
         random_phase(phase_no, $urandom_range(40, 80));
         phase_no++;
      end

      settle();
      repeat (12) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("wildcard_byte_pattern_search verification clean");
      else
         $display("wildcard_byte_pattern_search verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/wbps_pkg.sv
hdl/wbps_ifs.sv
hdl/wbps_csr.sv
hdl/wbps_scan.sv
hdl/wbps_rsp_fifo.sv
hdl/wildcard_byte_pattern_search.sv
dv/wbps_match_checker.sv
dv/tb_wildcard_byte_pattern_search.sv
